// File: rtl/core/rom_ram_bank_mapper_unit_defines.svh
// ----------------------------------------------------------------------------
// rom_ram_bank_mapper_unit_defines
// Assertion macros used by the top-level RTL file of the bank mapper.
// Each use expands to one labeled concurrent assertion clocked on clk and
// disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ROM_RAM_BANK_MAPPER_UNIT_DEFINES_SVH
`define ROM_RAM_BANK_MAPPER_UNIT_DEFINES_SVH

// Same-cycle implication
`define RRBM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define RRBM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/rrbm_pkg.sv
// ----------------------------------------------------------------------------
// rrbm_pkg
// Types and constants of the ROM/RAM bank mapper: bus transaction and
// response payloads, region and source codes, register indexes.
// ----------------------------------------------------------------------------
package rrbm_pkg;

	// Store sizes
	localparam int CART_RAM_BYTES = 8192;
	localparam int MAIN_RAM_BYTES = 8192;
	localparam int MAIN_AW        = $clog2(MAIN_RAM_BYTES);
	localparam int RAM_OFF_W      = 13;

	// Configuration port
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_ROM_SIZE    = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CART_FITTED = 8'd1;

	// Access kinds
	localparam logic KIND_READ  = 1'b0;
	localparam logic KIND_WRITE = 1'b1;

	// 8 KiB regions, top three address bits
	localparam logic [2:0] RGN_ROM_LO0 = 3'd0;
	localparam logic [2:0] RGN_ROM_LO1 = 3'd1;
	localparam logic [2:0] RGN_ROM_HI0 = 3'd2;
	localparam logic [2:0] RGN_ROM_HI1 = 3'd3;
	localparam logic [2:0] RGN_VRAM    = 3'd4;
	localparam logic [2:0] RGN_CART    = 3'd5;
	localparam logic [2:0] RGN_MAIN0   = 3'd6;
	localparam logic [2:0] RGN_MAIN1   = 3'd7;

	// Response source codes
	localparam logic [1:0] SRC_ROM = 2'd0;
	localparam logic [1:0] SRC_RAM = 2'd1;
	localparam logic [1:0] SRC_OFF = 2'd2;

	// Latch write key and disabled cart RAM read byte
	localparam logic [3:0] RAM_KEY      = 4'hA;
	localparam logic [7:0] DISABLED_BYTE = 8'hFF;

	typedef struct packed {
		logic        kind;
		logic [15:0] address;
		logic [7:0]  write_data;
	} req_t;

	typedef struct packed {
		logic [1:0]  source;
		logic [20:0] rom_address;
		logic [7:0]  read_data;
		logic [15:0] echo_address;
	} rsp_t;

	// Bank latch view handed to the datapath
	typedef struct packed {
		logic [20:0] rom_address;
		logic        cart_on;
	} xlat_t;

endpackage

// File: rtl/core/rom_ram_bank_mapper_unit.sv
// ----------------------------------------------------------------------------
// rom_ram_bank_mapper_unit
// Bank controller for a 16-bit bus: bank latches, ROM address translation,
// cart RAM and main RAM stores.
// ----------------------------------------------------------------------------
// Usage:
//   req (req_valid/req_stall) carries one bus transaction: kind, address and
//   write data. rsp (rsp_valid/rsp_stall) returns one response per read,
//   except reads of the video RAM region; writes give no response.
//   cfg (cfg_valid/cfg_ready) writes the ROM bank total (index 0) and the
//   cart RAM presence bit (index 1); other indexes are dropped. cfg_ready is
//   always high.
//   Read path: an accepted read is registered with the store read in the
//   read stage, then in the output register that drives rsp.
//   Throughput: one transaction per cycle while req_stall is low; a read
//   right after a write to the same byte sees the new data, since the store
//   writes at the edge where the write is accepted and reads after it.
//   Reset: latches, configuration registers and valid flags clear, then both
//   stores are zeroed by a sweep over CART_RAM_BYTES entries (8192 by default),
//   one byte a cycle, with req_stall high. Configuration writes are taken during the sweep.
//   Receiver stall: the output register holds; the read stage behind it
//   holds one more transaction, after which req_stall rises.
// ----------------------------------------------------------------------------
`include "rom_ram_bank_mapper_unit_defines.svh"

module rom_ram_bank_mapper_unit #(
	parameter int CART_RAM_BYTES = rrbm_pkg::CART_RAM_BYTES
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               req_valid,
	output logic                               req_stall,
	input  rrbm_pkg::req_t                     req,
	output logic                               rsp_valid,
	input  logic                               rsp_stall,
	output rrbm_pkg::rsp_t                     rsp,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [rrbm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rrbm_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int CART_AW = $clog2(CART_RAM_BYTES);
	localparam int MAIN_AW = rrbm_pkg::MAIN_AW;
	localparam logic [CART_AW-1:0] CLR_LAST = CART_AW'(CART_RAM_BYTES - 1);

	// Configuration registers
	logic [5:0] rom_size_q;
	logic       cart_fitted_q;

	// Clearing sweep
	logic               clearing_q;
	logic [CART_AW-1:0] clr_idx_q;

	// Read stage
	logic        valid_s1;
	logic [1:0]  src_s1;
	logic [20:0] rom_addr_s1;
	logic [15:0] addr_s1;
	logic        cart_sel_s1;

	// Output register
	logic           rsp_valid_q;
	rrbm_pkg::rsp_t rsp_q;

	logic            accept;
	logic            is_write;
	logic            is_read;
	logic [2:0]      region;
	logic            s1_adv;
	rrbm_pkg::xlat_t xlat;
	rrbm_pkg::rsp_t  rsp_next;

	logic               cart_wr_en;
	logic               cart_rd_en;
	logic [CART_AW-1:0] cart_addr;
	logic [7:0]         cart_wr_data;
	logic [7:0]         cart_rd_data;
	logic               main_wr_en;
	logic               main_rd_en;
	logic [MAIN_AW-1:0] main_addr;
	logic [7:0]         main_wr_data;
	logic [7:0]         main_rd_data;
	logic               in_cart;
	logic               in_main;

	// Handshake
	assign s1_adv    = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = clearing_q || (valid_s1 && !s1_adv);
	assign accept    = req_valid && !req_stall;
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign region   = req.address[15:13];
	assign is_write = accept && (req.kind == rrbm_pkg::KIND_WRITE);
	assign is_read  = accept && (req.kind == rrbm_pkg::KIND_READ)
		&& (region != rrbm_pkg::RGN_VRAM);
	assign in_cart  = (region == rrbm_pkg::RGN_CART);
	assign in_main  = (region == rrbm_pkg::RGN_MAIN0) || (region == rrbm_pkg::RGN_MAIN1);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_size_q    <= '0;
			cart_fitted_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				rrbm_pkg::CFG_ROM_SIZE:    rom_size_q    <= cfg_data[5:0];
				rrbm_pkg::CFG_CART_FITTED: cart_fitted_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Bank latches and ROM translation
	rrbm_bank_regs u_bank_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_en       (is_write),
		.req         (req),
		.rom_size    (rom_size_q),
		.cart_fitted (cart_fitted_q),
		.xlat        (xlat)
	);

	// Store clearing sweep after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clearing_q) begin
			if (clr_idx_q == CLR_LAST) begin
				clearing_q <= 1'b0;
			end
			clr_idx_q <= clr_idx_q + CART_AW'(1);
		end
	end

	// Store port control: sweep or bus transaction
	always_comb begin
		if (clearing_q) begin
			cart_wr_en   = 1'b1;
			cart_rd_en   = 1'b0;
			cart_addr    = clr_idx_q;
			cart_wr_data = '0;
			main_wr_en   = (32'(clr_idx_q) < 32'(rrbm_pkg::MAIN_RAM_BYTES));
			main_rd_en   = 1'b0;
			main_addr    = clr_idx_q[MAIN_AW-1:0];
			main_wr_data = '0;
		end else begin
			cart_wr_en   = is_write && in_cart && xlat.cart_on;
			cart_rd_en   = is_read && in_cart;
			cart_addr    = CART_AW'(req.address[rrbm_pkg::RAM_OFF_W-1:0]);
			cart_wr_data = req.write_data;
			main_wr_en   = is_write && in_main;
			main_rd_en   = is_read && in_main;
			main_addr    = req.address[MAIN_AW-1:0];
			main_wr_data = req.write_data;
		end
	end

	rrbm_ram #(
		.DEPTH (CART_RAM_BYTES),
		.AW    (CART_AW)
	) u_cart_ram (
		.clk     (clk),
		.wr_en   (cart_wr_en),
		.rd_en   (cart_rd_en),
		.addr    (cart_addr),
		.wr_data (cart_wr_data),
		.rd_data (cart_rd_data)
	);

	rrbm_ram #(
		.DEPTH (rrbm_pkg::MAIN_RAM_BYTES),
		.AW    (MAIN_AW)
	) u_main_ram (
		.clk     (clk),
		.wr_en   (main_wr_en),
		.rd_en   (main_rd_en),
		.addr    (main_addr),
		.wr_data (main_wr_data),
		.rd_data (main_rd_data)
	);

	// Read stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (is_read) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// Read stage payload, taken with the store read
	always_ff @(posedge clk) begin
		if (is_read) begin
			addr_s1     <= req.address;
			cart_sel_s1 <= in_cart;
			rom_addr_s1 <= xlat.rom_address;
			if (in_cart) begin
				src_s1 <= xlat.cart_on ? rrbm_pkg::SRC_RAM : rrbm_pkg::SRC_OFF;
			end else if (in_main) begin
				src_s1 <= rrbm_pkg::SRC_RAM;
			end else begin
				src_s1 <= rrbm_pkg::SRC_ROM;
			end
		end
	end

	// Response assembly
	always_comb begin
		rsp_next.source       = src_s1;
		rsp_next.echo_address = addr_s1;
		rsp_next.rom_address  = '0;
		rsp_next.read_data    = '0;
		case (src_s1)
			rrbm_pkg::SRC_ROM: rsp_next.rom_address = rom_addr_s1;
			rrbm_pkg::SRC_RAM: rsp_next.read_data = cart_sel_s1 ? cart_rd_data : main_rd_data;
			rrbm_pkg::SRC_OFF: rsp_next.read_data = rrbm_pkg::DISABLED_BYTE;
			default: ;
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (s1_adv) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			rsp_q <= rsp_next;
		end
	end

	// Checks
	`RRBM_ASSERT_NOW(a_no_req_while_clearing, clearing_q, req_stall,
		"transaction accepted during store clearing")
	`RRBM_ASSERT_NOW(a_no_s1_overrun, valid_s1 && rsp_valid_q && rsp_stall, req_stall,
		"read stage overwritten while output is stalled")
	`RRBM_ASSERT_NOW(a_off_payload, rsp_valid && (rsp.source == rrbm_pkg::SRC_OFF),
		(rsp.read_data == rrbm_pkg::DISABLED_BYTE) && (rsp.rom_address == '0),
		"disabled cart RAM response carries wrong payload")
	`RRBM_ASSERT_NEXT(a_sweep_full, clearing_q && (clr_idx_q != CLR_LAST), clearing_q,
		"store clearing ended before the last entry")

endmodule

// File: rtl/core/rrbm_ram.sv
// ----------------------------------------------------------------------------
// rrbm_ram
// Single-port synchronous byte store, one read or write per cycle,
// registered read data.
// ----------------------------------------------------------------------------
module rrbm_ram #(
	parameter int DEPTH = rrbm_pkg::CART_RAM_BYTES,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic          rd_en,
	input  logic [AW-1:0] addr,
	input  logic [7:0]    wr_data,
	output logic [7:0]    rd_data
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rd_data_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr] <= wr_data;
		end
	end

	// Read port, data held until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: rtl/core/rrbm_bank_regs.sv
// ----------------------------------------------------------------------------
// rrbm_bank_regs
// Bank latches (RAM enable, low bank, high bank, mode) and the ROM address
// translation for reads in the ROM regions.
// ----------------------------------------------------------------------------
module rrbm_bank_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  rrbm_pkg::req_t      req,
	input  logic [5:0]          rom_size,
	input  logic                cart_fitted,
	output rrbm_pkg::xlat_t     xlat
);

	logic       ram_enabled_q;
	logic [4:0] bank_low_q;
	logic [1:0] bank_high_q;
	logic       banking_mode_q;

	logic [2:0] region;
	logic [5:0] bank_mask;
	logic [6:0] bank_std;
	logic [6:0] bank_mode1;

	assign region = req.address[15:13];

	// Latch writes from bus write transactions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ram_enabled_q  <= 1'b0;
			bank_low_q     <= '0;
			bank_high_q    <= '0;
			banking_mode_q <= 1'b0;
		end else if (wr_en) begin
			unique case (region)
				rrbm_pkg::RGN_ROM_LO0:
					ram_enabled_q <= (req.write_data[3:0] == rrbm_pkg::RAM_KEY);
				rrbm_pkg::RGN_ROM_LO1: bank_low_q     <= req.write_data[4:0];
				rrbm_pkg::RGN_ROM_HI0: bank_high_q    <= req.write_data[1:0];
				rrbm_pkg::RGN_ROM_HI1: banking_mode_q <= req.write_data[0];
				default: ;
			endcase
		end
	end

	// Bank numbers; a bank count of zero leaves the standard bank unmasked and zeroes the mode 1 bank
	always_comb begin
		bank_mask = rom_size - 6'd1;
		bank_std  = {bank_high_q, bank_low_q} | {6'd0, (bank_low_q == 5'd0)};
		if (rom_size != 6'd0) begin
			bank_std = bank_std & {1'b0, bank_mask};
		end
		if (rom_size != 6'd0) begin
			bank_mode1 = {bank_high_q, 5'd0} & {1'b0, bank_mask};
		end else begin
			bank_mode1 = '0;
		end
	end

	// ROM byte address by region
	always_comb begin
		unique case (region) inside
			rrbm_pkg::RGN_ROM_LO0, rrbm_pkg::RGN_ROM_LO1: begin
				if (banking_mode_q) begin
					xlat.rom_address = {bank_mode1, req.address[13:0]};
				end else begin
					xlat.rom_address = {6'd0, req.address[14:0]};
				end
			end
			rrbm_pkg::RGN_ROM_HI0, rrbm_pkg::RGN_ROM_HI1: begin
				xlat.rom_address = {bank_std, req.address[13:0]};
			end
			default: xlat.rom_address = '0;
		endcase
		xlat.cart_on = ram_enabled_q & cart_fitted;
	end

endmodule

// File: verif/rom_ram_bank_mapper_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rom_ram_bank_mapper_unit_tb
// Self-checking bench for the bank mapper. A shadow copy of the bank latches,
// register settings and both RAM stores predicts each read response. Bus
// transactions are driven with random gaps and random response stalls,
// including one long receiver hold-off. The bench steps through several
// ROM bank count and cart RAM presence settings.
// ----------------------------------------------------------------------------
module rom_ram_bank_mapper_unit_tb;
	import rrbm_pkg::*;

	// Shadow of the mapper state; queues the responses that reads will give
	class access_shadow;
		logic [5:0] rom_size;
		logic       cart_present;
		logic       cart_on;
		logic [4:0] bank_lo;
		logic [1:0] bank_hi;
		logic       mode_sel;
		logic [7:0] cart_bytes [CART_RAM_BYTES];
		logic [7:0] main_bytes [MAIN_RAM_BYTES];
		rsp_t       pending_reads [$];
		int         fails;
		int         reported;
		int         n_rom;
		int         n_ram;
		int         n_off;
		int         n_writes;

		function void clear();
			rom_size     = '0;
			cart_present = 1'b0;
			cart_on      = 1'b0;
			bank_lo      = '0;
			bank_hi      = '0;
			mode_sel     = 1'b0;
			foreach (cart_bytes[i]) cart_bytes[i] = '0;
			foreach (main_bytes[i]) main_bytes[i] = '0;
			pending_reads.delete();
			fails = 0; reported = 0;
			n_rom = 0; n_ram = 0; n_off = 0; n_writes = 0;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				CFG_ROM_SIZE:    rom_size = val[5:0];
				CFG_CART_FITTED: cart_present = val[0];
				default: ;
			endcase
		endfunction

		// Apply one accepted bus transaction
		function void take_access(req_t a);
			logic [2:0]  rgn;
			logic [12:0] off;
			logic [6:0]  bank;
			rsp_t        r;
			rgn = a.address[15:13];
			off = a.address[12:0];
			if (a.kind == KIND_WRITE) begin
				n_writes++;
				case (rgn)
					RGN_ROM_LO0: cart_on = (a.write_data[3:0] == RAM_KEY);
					RGN_ROM_LO1: bank_lo = a.write_data[4:0];
					RGN_ROM_HI0: bank_hi = a.write_data[1:0];
					RGN_ROM_HI1: mode_sel = a.write_data[0];
					RGN_CART: if (cart_on && cart_present) cart_bytes[off] = a.write_data;
					RGN_MAIN0, RGN_MAIN1: main_bytes[off] = a.write_data;
					default: ;
				endcase
				return;
			end
			// video RAM reads give no response
			if (rgn == RGN_VRAM)
				return;
			r = '0;
			r.echo_address = a.address;
			case (rgn)
				RGN_ROM_LO0, RGN_ROM_LO1: begin
					r.source = SRC_ROM;
					if (!mode_sel) begin
						r.rom_address = {6'd0, a.address[14:0]};
					end else begin
						bank = (rom_size == 6'd0) ? 7'd0 :
							({bank_hi, 5'd0} & {1'b0, rom_size - 6'd1});
						r.rom_address = {bank, a.address[13:0]};
					end
				end
				RGN_ROM_HI0, RGN_ROM_HI1: begin
					r.source = SRC_ROM;
					bank = {bank_hi, bank_lo};
					// low bank zero reads as bank one
					if (bank_lo == 5'd0) bank[0] = 1'b1;
					if (rom_size != 6'd0) bank = bank & {1'b0, rom_size - 6'd1};
					r.rom_address = {bank, a.address[13:0]};
				end
				RGN_CART: begin
					if (cart_on && cart_present) begin
						r.source    = SRC_RAM;
						r.read_data = cart_bytes[off];
					end else begin
						r.source    = SRC_OFF;
						r.read_data = DISABLED_BYTE;
					end
				end
				default: begin
					r.source    = SRC_RAM;
					r.read_data = main_bytes[off];
				end
			endcase
			pending_reads.push_back(r);
		endfunction

		function void flag(string what, rsp_t want, rsp_t got);
			fails++;
			if (reported < 10) begin
				reported++;
				$display("%0t mismatch (%s): expected src %0d rom %h data %h addr %h,",
					$realtime, what, want.source, want.rom_address, want.read_data,
					want.echo_address);
				$display("    got src %0d rom %h data %h addr %h",
					got.source, got.rom_address, got.read_data, got.echo_address);
			end
		endfunction

		// Compare one accepted response with the oldest queued one
		function void match_response(rsp_t got);
			rsp_t want;
			if (pending_reads.size() == 0) begin
				flag("no read outstanding", '0, got);
				return;
			end
			want = pending_reads.pop_front();
			case (want.source)
				SRC_ROM: n_rom++;
				SRC_RAM: n_ram++;
				default: n_off++;
			endcase
			if (got.source !== want.source || got.rom_address !== want.rom_address ||
					got.read_data !== want.read_data || got.echo_address !== want.echo_address)
				flag("field", want, got);
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  req_valid;
	logic                  req_stall;
	req_t                  req;
	logic                  rsp_valid;
	logic                  rsp_stall;
	rsp_t                  rsp;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	access_shadow sb = new();
	logic quiet       = 1'b0;
	logic pressure_go = 1'b0;
	int   n_settings  = 0;

	rom_ram_bank_mapper_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the handshakes hang
	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// Sample accepted transactions on both channels
	always @(posedge clk) begin
		if (arst_n && req_valid && !req_stall) sb.take_access(req);
		if (arst_n && rsp_valid && !rsp_stall) sb.match_response(rsp);
	end

	// Receiver: random stall bursts, one long hold-off on request
	initial begin
		int run;
		run = 0;
		rsp_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (pressure_go) begin
				pressure_go = 1'b0;
				rsp_stall = 1'b1;
				repeat (400) @(negedge clk);
				rsp_stall = 1'b0;
				run = 0;
			end else if (quiet) begin
				rsp_stall = 1'b0;
			end else if (run > 0) begin
				run--;
			end else if ($urandom_range(0, 3) == 0) begin
				rsp_stall = 1'b1;
				run = $urandom_range(1, 18) - 1;
			end else begin
				rsp_stall = 1'b0;
				run = $urandom_range(0, 40);
			end
		end
	end

	function automatic req_t access(logic kind, logic [15:0] addr, logic [7:0] data);
		req_t a;
		a.kind       = kind;
		a.address    = addr;
		a.write_data = data;
		return a;
	endfunction

	// Mostly well-formed traffic: latch writes, ROM reads, RAM traffic on a
	// small hot offset set so reads return written bytes, plus raw noise
	function automatic req_t random_access();
		req_t        a;
		int          pick;
		logic [12:0] off;
		pick = $urandom_range(0, 99);
		off = $urandom_range(0, 1) ? 13'($urandom_range(0, 15)) : 13'($urandom);
		a.kind       = 1'($urandom_range(0, 1));
		a.address    = 16'($urandom);
		a.write_data = 8'($urandom);
		if (pick < 15) begin
			a.kind = KIND_WRITE;
			a.address[15:13] = 3'($urandom_range(0, 3));
			if (a.address[15:13] == RGN_ROM_LO0 && $urandom_range(0, 2) != 0)
				a.write_data[3:0] = RAM_KEY;
		end else if (pick < 35) begin
			a.kind = KIND_READ;
			a.address[15] = 1'b0;
		end else if (pick < 55) begin
			a.address = {RGN_CART, off};
		end else if (pick < 72) begin
			a.address = {($urandom_range(0, 1) ? RGN_MAIN0 : RGN_MAIN1), off};
		end else if (pick < 78) begin
			a.address[15:13] = RGN_VRAM;
		end
		return a;
	endfunction

	// Offer one transaction, after a random gap unless in the quiet tail
	task send_access(input req_t a);
		int gap;
		gap = (!quiet && $urandom_range(0, 4) == 0) ? $urandom_range(1, 18) : 0;
		@(negedge clk);
		if (gap > 0) begin
			req_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req       = a;
		req_valid = 1'b1;
		do @(posedge clk); while (req_stall);
	endtask

	task write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		do @(posedge clk); while (!cfg_ready);
		sb.set_register(idx, val);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Drop valid, wait for every response, then let the pipeline empty
	task settle(input int tail);
		@(negedge clk);
		req_valid = 1'b0;
		while (sb.pending_reads.size() != 0) @(posedge clk);
		repeat (tail) @(posedge clk);
	endtask

	initial begin
		logic [5:0] rom_set [8];
		logic       ram_set [8];
		req_t       a;
		int         counted;
		rom_set = '{6'd0, 6'd32, 6'd2, 6'd1, 6'd63, 6'd16, 6'd4, 6'd37};
		ram_set = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};

		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		sb.clear();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Registers are taken during the clearing sweep
		write_register(CFG_ROM_SIZE, 8'd0);
		write_register(CFG_CART_FITTED, 8'd1);
		n_settings++;

		// Directed: ROM address bounds, low bank zero, masking off, cart enable, RAM, video RAM
		send_access(access(KIND_READ,  16'h0000, 8'h00));
		send_access(access(KIND_READ,  16'h3FFF, 8'hFF));
		send_access(access(KIND_READ,  16'h4000, 8'h00));
		send_access(access(KIND_WRITE, 16'h2000, 8'h1F));
		send_access(access(KIND_WRITE, 16'h4000, 8'hFF));
		send_access(access(KIND_READ,  16'h7FFF, 8'h00));
		send_access(access(KIND_WRITE, 16'h6000, 8'h01));
		send_access(access(KIND_READ,  16'h1234, 8'h00));
		send_access(access(KIND_READ,  16'hA000, 8'h00));
		send_access(access(KIND_WRITE, 16'hA000, 8'h55));
		send_access(access(KIND_WRITE, 16'h0000, 8'hFA));
		send_access(access(KIND_WRITE, 16'hBFFF, 8'hAA));
		send_access(access(KIND_READ,  16'hBFFF, 8'h00));
		send_access(access(KIND_READ,  16'hA000, 8'h00));
		send_access(access(KIND_WRITE, 16'hC000, 8'hFF));
		send_access(access(KIND_READ,  16'hC000, 8'h00));
		send_access(access(KIND_WRITE, 16'hFFFF, 8'h00));
		send_access(access(KIND_READ,  16'hFFFF, 8'h00));
		send_access(access(KIND_READ,  16'hE123, 8'h00));
		send_access(access(KIND_WRITE, 16'h8000, 8'h77));
		send_access(access(KIND_READ,  16'h9FFF, 8'h00));
		send_access(access(KIND_WRITE, 16'h3FFF, 8'hE0));
		send_access(access(KIND_READ,  16'h5555, 8'h00));
		send_access(access(KIND_WRITE, 16'h1FFF, 8'h0B));
		send_access(access(KIND_READ,  16'hA001, 8'h00));

		// Random phases, one register setting each
		for (int p = 0; p < 8; p++) begin
			settle(4);
			write_register(CFG_ROM_SIZE, {2'($urandom), rom_set[p]});
			write_register(CFG_CART_FITTED, {7'($urandom), ram_set[p]});
			// indexes past the list are dropped
			if (p % 3 == 0)
				write_register($urandom_range(0, 1) ? 8'd2 : 8'd255, 8'($urandom));
			n_settings++;
			if (p == 1) pressure_go = 1'b1;
			if (p == 7) quiet = 1'b1;
			counted = 0;
			while (counted < 110) begin
				a = random_access();
				send_access(a);
				if (a.address[15:13] != RGN_VRAM) counted++;
			end
		end

		settle(20);
		$display("Covered %0d writes and %0d reads (%0d ROM, %0d RAM, %0d cart off)",
			sb.n_writes, sb.n_rom + sb.n_ram + sb.n_off, sb.n_rom, sb.n_ram, sb.n_off);
		$display("over %0d register settings; mismatches: %0d", n_settings, sb.fails);
		if (sb.fails == 0 && sb.pending_reads.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/rrbm_pkg.sv
rtl/core/rrbm_ram.sv
rtl/core/rrbm_bank_regs.sv
rtl/core/rom_ram_bank_mapper_unit.sv
verif/rom_ram_bank_mapper_unit_tb.sv
